>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/irpdt_pkg.sv
// Shared types, register indexes and reset values of the IR transmitter
package irpdt_pkg;

  localparam int unsigned CMD_WORD_W     = 32;
  localparam int unsigned COMMAND_BITS_D = 32;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned GAP_W          = 18;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [LEN_W-1:0] RST_CARRIER_HALF = 16'd53;
  localparam logic [LEN_W-1:0] RST_HDR_MARK     = 16'd18000;
  localparam logic [LEN_W-1:0] RST_HDR_SPACE    = 16'd18000;
  localparam logic [LEN_W-1:0] RST_BIT_MARK     = 16'd2240;
  localparam logic [LEN_W-1:0] RST_ONE_SPACE    = 16'd6760;
  localparam logic [LEN_W-1:0] RST_ZERO_SPACE   = 16'd2240;
  localparam logic [GAP_W-1:0] RST_STOP_GAP     = 18'd200000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_HALF = 3'd0,
    REG_HDR_MARK     = 3'd1,
    REG_HDR_SPACE    = 3'd2,
    REG_BIT_MARK     = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_ZERO_SPACE   = 3'd5,
    REG_STOP_GAP     = 3'd6
  } cfg_reg_t;

  // Frame phases
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_HDR_MARK    = 3'd1,
    PH_HDR_SPACE   = 3'd2,
    PH_BIT_MARK    = 3'd3,
    PH_BIT_SPACE   = 3'd4,
    PH_TRAIL_MARK  = 3'd5,
    PH_TRAIL_SPACE = 3'd6,
    PH_STOP        = 3'd7
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] carrier_half;
    logic [LEN_W-1:0] hdr_mark;
    logic [LEN_W-1:0] hdr_space;
    logic [LEN_W-1:0] bit_mark;
    logic [LEN_W-1:0] one_space;
    logic [LEN_W-1:0] zero_space;
    logic [GAP_W-1:0] stop_gap;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic start_refused;
  } result_t;

  // Phases that drive the carrier
  function automatic logic is_mark(input phase_t ph);
    return (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_TRAIL_MARK);
  endfunction

endpackage

>>> hw/rtl/ir_pulse_distance_transmitter.sv
// Top level of the pulse-distance IR transmitter
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  in      | in_valid  | in_stall  | in_opcode, in_command_word
//  out     | out_valid | out_stall | out_ir_level, out_busy_res, out_frame_done,
//          |           |           | out_start_refused
//  cfg     | cfg_we    | -         | cfg_index, cfg_wdata
//
// One request per clock while in_stall is low; its result is registered in the output register.
// The sequencer state is updated in the cycle a request is taken, so requests
// can follow each other in every cycle.
// in_stall is high only in reset and while an untaken result sits in the output
// register and out_stall is high.
// Reset is synchronous; it clears sequencer and out_valid; config takes defaults.
module ir_pulse_distance_transmitter #(
  parameter int unsigned COMMAND_BITS = irpdt_pkg::COMMAND_BITS_D
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [irpdt_pkg::CMD_WORD_W-1:0]    in_command_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_ir_level,
  output logic                                out_busy_res,
  output logic                                out_frame_done,
  output logic                                out_start_refused,
  input  logic                                cfg_we,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpdt_pkg::GAP_W-1:0]         cfg_wdata
);

  irpdt_pkg::cfg_t    cfg;
  irpdt_pkg::result_t res;
  irpdt_pkg::result_t res_r;
  logic               out_valid_r, out_valid_nxt;
  logic               in_take;

  irpdt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input side stalls in reset and when the output register cannot drain
  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;

  irpdt_core #(
    .COMMAND_BITS (COMMAND_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_take),
    .opcode       (in_opcode),
    .command_word (in_command_word),
    .cfg          (cfg),
    .res          (res)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ir_level      = res_r.ir_level;
  assign out_busy_res      = res_r.busy_res;
  assign out_frame_done    = res_r.frame_done;
  assign out_start_refused = res_r.start_refused;

endmodule

>>> hw/rtl/irpdt_cfg.sv
// Configuration register file of the IR transmitter
module irpdt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [irpdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irpdt_pkg::GAP_W-1:0]         cfg_wdata,
  output irpdt_pkg::cfg_t                     cfg
);

  irpdt_pkg::cfg_t cfg_r;
  irpdt_pkg::cfg_t cfg_nxt;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        irpdt_pkg::REG_CARRIER_HALF: cfg_nxt.carrier_half = cfg_wdata[irpdt_pkg::LEN_W-1:0];
        irpdt_pkg::REG_HDR_MARK:     cfg_nxt.hdr_mark     = cfg_wdata[irpdt_pkg::LEN_W-1:0];
        irpdt_pkg::REG_HDR_SPACE:    cfg_nxt.hdr_space    = cfg_wdata[irpdt_pkg::LEN_W-1:0];
        irpdt_pkg::REG_BIT_MARK:     cfg_nxt.bit_mark     = cfg_wdata[irpdt_pkg::LEN_W-1:0];
        irpdt_pkg::REG_ONE_SPACE:    cfg_nxt.one_space    = cfg_wdata[irpdt_pkg::LEN_W-1:0];
        irpdt_pkg::REG_ZERO_SPACE:   cfg_nxt.zero_space   = cfg_wdata[irpdt_pkg::LEN_W-1:0];
        irpdt_pkg::REG_STOP_GAP:     cfg_nxt.stop_gap     = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_half <= irpdt_pkg::RST_CARRIER_HALF;
      cfg_r.hdr_mark     <= irpdt_pkg::RST_HDR_MARK;
      cfg_r.hdr_space    <= irpdt_pkg::RST_HDR_SPACE;
      cfg_r.bit_mark     <= irpdt_pkg::RST_BIT_MARK;
      cfg_r.one_space    <= irpdt_pkg::RST_ONE_SPACE;
      cfg_r.zero_space   <= irpdt_pkg::RST_ZERO_SPACE;
      cfg_r.stop_gap     <= irpdt_pkg::RST_STOP_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/irpdt_core.sv
// Frame sequencer: phase, bit and carrier counters, one request per cycle while step is high
module irpdt_core #(
  parameter int unsigned COMMAND_BITS = irpdt_pkg::COMMAND_BITS_D
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                opcode,
  input  logic [irpdt_pkg::CMD_WORD_W-1:0]    command_word,
  input  irpdt_pkg::cfg_t                     cfg,
  output irpdt_pkg::result_t                  res
);

  localparam int unsigned BL_W = $clog2(COMMAND_BITS + 1);
  localparam logic [BL_W-1:0] BITS_FULL = BL_W'(COMMAND_BITS);
  localparam int unsigned LEN_W = irpdt_pkg::LEN_W;
  localparam int unsigned GAP_W = irpdt_pkg::GAP_W;

  irpdt_pkg::phase_t          phase_r, phase_nxt;
  logic [BL_W-1:0]            bits_left_r, bits_left_nxt;
  logic [COMMAND_BITS-1:0]    shift_r, shift_nxt;
  logic [GAP_W-1:0]           phase_cnt_r, phase_cnt_nxt;
  logic [LEN_W-1:0]           carr_cnt_r, carr_cnt_nxt;
  logic                       carr_lvl_r, carr_lvl_nxt;

  logic                       start;
  logic                       active;
  logic                       cur_bit;
  logic [GAP_W-1:0]           len_raw;
  logic [GAP_W-1:0]           len_eff;
  logic [GAP_W:0]             phase_cnt_inc;
  logic                       phase_end;
  logic [LEN_W-1:0]           half_eff;
  logic [LEN_W:0]             carr_cnt_inc;
  logic                       carr_wrap;
  logic [BL_W-1:0]            bits_dec;
  irpdt_pkg::phase_t          ph_after;

  assign start   = opcode;
  assign active  = (phase_r != irpdt_pkg::PH_IDLE);
  // Bits go out MSB first, so the current bit sits at the top
  assign cur_bit = (bits_left_r != '0) && shift_r[COMMAND_BITS-1];

  // Length of the running phase; zero counts as one tick
  always_comb begin
    case (phase_r)
      irpdt_pkg::PH_HDR_MARK:    len_raw = GAP_W'(cfg.hdr_mark);
      irpdt_pkg::PH_HDR_SPACE:   len_raw = GAP_W'(cfg.hdr_space);
      irpdt_pkg::PH_BIT_MARK:    len_raw = GAP_W'(cfg.bit_mark);
      irpdt_pkg::PH_BIT_SPACE:   len_raw = cur_bit ? GAP_W'(cfg.one_space)
                                                   : GAP_W'(cfg.zero_space);
      irpdt_pkg::PH_TRAIL_MARK:  len_raw = GAP_W'(cfg.bit_mark);
      irpdt_pkg::PH_TRAIL_SPACE: len_raw = GAP_W'(cfg.zero_space);
      irpdt_pkg::PH_STOP:        len_raw = cfg.stop_gap;
      default:                   len_raw = GAP_W'(1);
    endcase
  end

  assign len_eff       = (len_raw == '0) ? GAP_W'(1) : len_raw;
  assign phase_cnt_inc = {1'b0, phase_cnt_r} + (GAP_W+1)'(1);
  assign phase_end     = (phase_cnt_inc >= {1'b0, len_eff});

  // Carrier half-period counter
  assign half_eff     = (cfg.carrier_half == '0) ? LEN_W'(1) : cfg.carrier_half;
  assign carr_cnt_inc = {1'b0, carr_cnt_r} + (LEN_W+1)'(1);
  assign carr_wrap    = (carr_cnt_inc >= {1'b0, half_eff});

  assign bits_dec = (bits_left_r != '0) ? bits_left_r - BL_W'(1) : bits_left_r;

  // Phase that follows the running one
  always_comb begin
    case (phase_r)
      irpdt_pkg::PH_HDR_MARK:    ph_after = irpdt_pkg::PH_HDR_SPACE;
      irpdt_pkg::PH_HDR_SPACE:   ph_after = (bits_left_r != '0) ? irpdt_pkg::PH_BIT_MARK
                                                                : irpdt_pkg::PH_TRAIL_MARK;
      irpdt_pkg::PH_BIT_MARK:    ph_after = irpdt_pkg::PH_BIT_SPACE;
      irpdt_pkg::PH_BIT_SPACE:   ph_after = (bits_dec != '0) ? irpdt_pkg::PH_BIT_MARK
                                                             : irpdt_pkg::PH_TRAIL_MARK;
      irpdt_pkg::PH_TRAIL_MARK:  ph_after = irpdt_pkg::PH_TRAIL_SPACE;
      irpdt_pkg::PH_TRAIL_SPACE: ph_after = irpdt_pkg::PH_STOP;
      default:                   ph_after = irpdt_pkg::PH_IDLE;
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    bits_left_nxt = bits_left_r;
    shift_nxt     = shift_r;
    phase_cnt_nxt = phase_cnt_r;
    carr_cnt_nxt  = carr_cnt_r;
    carr_lvl_nxt  = carr_lvl_r;
    if (step) begin
      if (start) begin
        if (!active) begin
          shift_nxt     = COMMAND_BITS'(command_word);
          bits_left_nxt = BITS_FULL;
          phase_nxt     = irpdt_pkg::PH_HDR_MARK;
          phase_cnt_nxt = '0;
          carr_cnt_nxt  = '0;
          carr_lvl_nxt  = 1'b1;
        end
      end else if (active) begin
        if (irpdt_pkg::is_mark(phase_r)) begin
          carr_cnt_nxt = carr_wrap ? '0 : carr_cnt_inc[LEN_W-1:0];
          carr_lvl_nxt = carr_lvl_r ^ carr_wrap;
        end
        phase_cnt_nxt = phase_cnt_inc[GAP_W-1:0];
        if (phase_end) begin
          if (phase_r == irpdt_pkg::PH_BIT_SPACE) begin
            bits_left_nxt = bits_dec;
            shift_nxt     = shift_r << 1;
          end
          phase_nxt     = ph_after;
          phase_cnt_nxt = '0;
          carr_cnt_nxt  = '0;
          carr_lvl_nxt  = irpdt_pkg::is_mark(ph_after);
        end
      end
    end
  end

  // Result of the request
  always_comb begin
    res = '0;
    if (start) begin
      res.busy_res      = 1'b1;
      res.start_refused = active;
    end else if (active) begin
      res.busy_res   = 1'b1;
      res.ir_level   = irpdt_pkg::is_mark(phase_r) && carr_lvl_r;
      res.frame_done = phase_end && (phase_r == irpdt_pkg::PH_STOP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= irpdt_pkg::PH_IDLE;
      bits_left_r <= '0;
      shift_r     <= '0;
      phase_cnt_r <= '0;
      carr_cnt_r  <= '0;
      carr_lvl_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bits_left_r <= bits_left_nxt;
      shift_r     <= shift_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      carr_cnt_r  <= carr_cnt_nxt;
      carr_lvl_r  <= carr_lvl_nxt;
    end
  end

endmodule

>>> hw/rtl/irpdt_chk.sv
// Port-level checker for the IR transmitter, bound to the top level
`include "assert_macros.svh"

module irpdt_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_opcode,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_ir_level,
  input logic                                out_busy_res,
  input logic                                out_frame_done,
  input logic                                out_start_refused
);

  // A taken request always yields a result in the next cycle
  `ASSERT_NEXT(a_req_to_result, clk, rst_n, in_valid && !in_stall, out_valid, "request lost")

  // A start request never drives the emitter and always reports busy
  `ASSERT_NEXT(a_start_result, clk, rst_n, in_valid && !in_stall && in_opcode, out_busy_res && !out_ir_level, "bad start result")

  // End of frame and refusal only happen while busy, with the emitter off
  `ASSERT_SAME(a_flags_busy, clk, rst_n, out_valid && (out_frame_done || out_start_refused), out_busy_res && !out_ir_level, "flag outside frame")

  // A held result keeps its payload
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_ir_level) && $stable(out_busy_res) && $stable(out_frame_done) && $stable(out_start_refused), "held result changed")

endmodule

bind ir_pulse_distance_transmitter irpdt_chk u_irpdt_chk (.*);

>>> tb/tb_ir_pulse_distance_transmitter.sv
// Self-checking testbench for the pulse-distance IR transmitter
module tb_ir_pulse_distance_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BITS = irpdt_pkg::COMMAND_BITS_D;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_START = 1'b1;
  // index past the register list, must be ignored
  localparam logic [irpdt_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SEGMENTS = 4;
  localparam int unsigned SEG_REQS = 30;
  localparam int unsigned MAX_REPORTS = 100;

  typedef struct packed {
    logic                             opcode;
    logic [irpdt_pkg::CMD_WORD_W-1:0] word;
  } ir_req_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_opcode = 1'b0;
  logic [irpdt_pkg::CMD_WORD_W-1:0] in_command_word = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_ir_level;
  logic                             out_busy_res;
  logic                             out_frame_done;
  logic                             out_start_refused;
  logic                             cfg_we = 1'b0;
  logic [irpdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [irpdt_pkg::GAP_W-1:0]      cfg_wdata = '0;

  ir_req_t              pending_reqs[$];
  irpdt_pkg::result_t   expected_levels[$];
  logic                 in_fire = 1'b0;
  int unsigned          gap_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          mismatches = 0;
  int unsigned          quiet_cycles = 0;

  // Transmitter model state and register copy
  irpdt_pkg::cfg_t                  tx_cfg;
  irpdt_pkg::phase_t                tx_phase;
  int unsigned                      tx_bits_left;
  int unsigned                      tx_phase_cnt;
  int unsigned                      tx_carrier_cnt;
  logic                             tx_carrier;
  logic [irpdt_pkg::CMD_WORD_W-1:0] tx_word;

  ir_pulse_distance_transmitter #(
    .COMMAND_BITS(NUM_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_command_word  (in_command_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ir_level     (out_ir_level),
    .out_busy_res     (out_busy_res),
    .out_frame_done   (out_frame_done),
    .out_start_refused(out_start_refused),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic in_burst(irpdt_pkg::phase_t ph);
    return (ph == irpdt_pkg::PH_HDR_MARK) || (ph == irpdt_pkg::PH_BIT_MARK) ||
           (ph == irpdt_pkg::PH_TRAIL_MARK);
  endfunction

  // Bit being sent; positions beyond the word go out as zeros
  function automatic logic data_bit();
    if (tx_bits_left == 0 || tx_bits_left > irpdt_pkg::CMD_WORD_W) return 1'b0;
    return tx_word[tx_bits_left-1];
  endfunction

  function automatic int unsigned phase_len();
    int unsigned len;
    case (tx_phase)
      irpdt_pkg::PH_HDR_MARK:    len = tx_cfg.hdr_mark;
      irpdt_pkg::PH_HDR_SPACE:   len = tx_cfg.hdr_space;
      irpdt_pkg::PH_BIT_MARK:    len = tx_cfg.bit_mark;
      irpdt_pkg::PH_BIT_SPACE:   len = data_bit() ? tx_cfg.one_space : tx_cfg.zero_space;
      irpdt_pkg::PH_TRAIL_MARK:  len = tx_cfg.bit_mark;
      irpdt_pkg::PH_TRAIL_SPACE: len = tx_cfg.zero_space;
      irpdt_pkg::PH_STOP:        len = tx_cfg.stop_gap;
      default:                   len = 1;
    endcase
    // zero length counts as one tick
    return (len == 0) ? 1 : len;
  endfunction

  function automatic void goto_phase(irpdt_pkg::phase_t nxt);
    tx_phase = nxt;
    tx_phase_cnt = 0;
    tx_carrier_cnt = 0;
    tx_carrier = in_burst(nxt);
  endfunction

  // Advance the transmitter model by one request and return its result
  function automatic irpdt_pkg::result_t transmit_step(logic opcode,
                                                       logic [irpdt_pkg::CMD_WORD_W-1:0] word);
    irpdt_pkg::result_t r;
    int unsigned        half;
    r = '0;
    if (opcode == OP_START) begin
      if (tx_phase != irpdt_pkg::PH_IDLE) begin
        r.start_refused = 1'b1;
      end else begin
        tx_word = word;
        tx_bits_left = NUM_BITS;
        goto_phase(irpdt_pkg::PH_HDR_MARK);
      end
      r.busy_res = 1'b1;
    end else if (tx_phase != irpdt_pkg::PH_IDLE) begin
      r.busy_res = 1'b1;
      // carrier starts high and toggles every half period
      if (in_burst(tx_phase)) begin
        r.ir_level = tx_carrier;
        half = (tx_cfg.carrier_half == 0) ? 1 : tx_cfg.carrier_half;
        tx_carrier_cnt++;
        if (tx_carrier_cnt >= half) begin
          tx_carrier_cnt = 0;
          tx_carrier = ~tx_carrier;
        end
      end
      tx_phase_cnt++;
      if (tx_phase_cnt >= phase_len()) begin
        case (tx_phase)
          irpdt_pkg::PH_HDR_MARK:  goto_phase(irpdt_pkg::PH_HDR_SPACE);
          irpdt_pkg::PH_HDR_SPACE: goto_phase(tx_bits_left != 0 ? irpdt_pkg::PH_BIT_MARK
                                                                : irpdt_pkg::PH_TRAIL_MARK);
          irpdt_pkg::PH_BIT_MARK:  goto_phase(irpdt_pkg::PH_BIT_SPACE);
          irpdt_pkg::PH_BIT_SPACE: begin
            if (tx_bits_left != 0) tx_bits_left--;
            goto_phase(tx_bits_left != 0 ? irpdt_pkg::PH_BIT_MARK : irpdt_pkg::PH_TRAIL_MARK);
          end
          irpdt_pkg::PH_TRAIL_MARK:  goto_phase(irpdt_pkg::PH_TRAIL_SPACE);
          irpdt_pkg::PH_TRAIL_SPACE: goto_phase(irpdt_pkg::PH_STOP);
          default: begin
            r.frame_done = 1'b1;
            goto_phase(irpdt_pkg::PH_IDLE);
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0b, got %0b", name, want, got);
    end
  endtask

  // Request driver: holds a request until taken, random gaps between
  always @(negedge clk) begin
    ir_req_t req;
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
        req = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_opcode <= req.opcode;
        in_command_word <= req.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Monitor: score results, predict new requests, watchdog
  always @(posedge clk) begin
    irpdt_pkg::result_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          mismatches++;
          $error("result with no request outstanding");
        end else begin
          want = expected_levels.pop_front();
          check_field("ir_level", want.ir_level, out_ir_level);
          check_field("busy_res", want.busy_res, out_busy_res);
          check_field("frame_done", want.frame_done, out_frame_done);
          check_field("start_refused", want.start_refused, out_start_refused);
        end
      end
      if (in_valid && !in_stall)
        expected_levels.push_back(transmit_step(in_opcode, in_command_word));
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $error("watchdog: no transfer in %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void push_req(logic opcode, logic [irpdt_pkg::CMD_WORD_W-1:0] word);
    pending_reqs.push_back({opcode, word});
  endfunction

  task automatic write_reg(logic [irpdt_pkg::CFG_IDX_W-1:0] idx,
                           logic [irpdt_pkg::GAP_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      irpdt_pkg::REG_CARRIER_HALF: tx_cfg.carrier_half = val[irpdt_pkg::LEN_W-1:0];
      irpdt_pkg::REG_HDR_MARK:     tx_cfg.hdr_mark = val[irpdt_pkg::LEN_W-1:0];
      irpdt_pkg::REG_HDR_SPACE:    tx_cfg.hdr_space = val[irpdt_pkg::LEN_W-1:0];
      irpdt_pkg::REG_BIT_MARK:     tx_cfg.bit_mark = val[irpdt_pkg::LEN_W-1:0];
      irpdt_pkg::REG_ONE_SPACE:    tx_cfg.one_space = val[irpdt_pkg::LEN_W-1:0];
      irpdt_pkg::REG_ZERO_SPACE:   tx_cfg.zero_space = val[irpdt_pkg::LEN_W-1:0];
      irpdt_pkg::REG_STOP_GAP:     tx_cfg.stop_gap = val;
      default: ;
    endcase
  endtask

  // 16-bit registers get random junk above bit 15 to check masking
  task automatic load_config(int unsigned ch, int unsigned hm, int unsigned hs,
                             int unsigned bm, int unsigned os, int unsigned zs,
                             int unsigned sg);
    write_reg(irpdt_pkg::REG_CARRIER_HALF, {2'($urandom), 16'(ch)});
    write_reg(irpdt_pkg::REG_HDR_MARK, {2'($urandom), 16'(hm)});
    write_reg(irpdt_pkg::REG_HDR_SPACE, {2'($urandom), 16'(hs)});
    write_reg(irpdt_pkg::REG_BIT_MARK, {2'($urandom), 16'(bm)});
    write_reg(irpdt_pkg::REG_ONE_SPACE, {2'($urandom), 16'(os)});
    write_reg(irpdt_pkg::REG_ZERO_SPACE, {2'($urandom), 16'(zs)});
    write_reg(irpdt_pkg::REG_STOP_GAP, 18'(sg));
  endtask

  // Wait until every queued request is taken and every result checked
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Feed ticks until the frame is over, then let all results drain
  task automatic finish_frame();
    while (tx_phase != irpdt_pkg::PH_IDLE || pending_reqs.size() != 0 || in_valid) begin
      if (tx_phase != irpdt_pkg::PH_IDLE && pending_reqs.size() < 4)
        repeat (4) push_req(OP_TICK, '0);
      @(posedge clk);
    end
    drain();
  endtask

  initial begin
    tx_cfg = '{16'd53, 16'd18000, 16'd18000, 16'd2240, 16'd6760, 16'd2240, 18'd200000};
    tx_phase = irpdt_pkg::PH_IDLE;
    tx_bits_left = 0;
    tx_phase_cnt = 0;
    tx_carrier_cnt = 0;
    tx_carrier = 1'b0;
    tx_word = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: idle tick, refused start, header carrier toggle
    push_req(OP_TICK, 32'h1234_5678);
    push_req(OP_START, 32'h8000_0001);
    push_req(OP_START, 32'hFFFF_FFFF);
    repeat (60) push_req(OP_TICK, '0);
    drain();

    // Zero lengths act as one tick; carrier toggles every tick
    load_config(0, 0, 0, 0, 0, 0, 0);
    finish_frame();
    write_reg(REG_SPARE, '1);
    push_req(OP_START, 32'h0000_0000);
    push_req(OP_TICK, '0);
    push_req(OP_START, 32'hFFFF_FFFF);
    push_req(OP_TICK, '0);
    finish_frame();

    // Distinct short lengths
    load_config(2, 4, 5, 1, 3, 2, 6);
    push_req(OP_START, 32'h5A3C_96E1);
    push_req(OP_START, 32'h0F0F_0F0F);
    finish_frame();

    // Largest values: long header burst, then a long stop gap cut short
    load_config(65535, 65535, 1, 1, 1, 1, 262143);
    push_req(OP_START, 32'hFFFF_FFFF);
    repeat (30) push_req(OP_TICK, '0);
    drain();
    write_reg(irpdt_pkg::REG_HDR_MARK, 18'd1);
    repeat (100) push_req(OP_TICK, '0);
    drain();
    load_config(0, 0, 0, 0, 0, 0, 0);
    finish_frame();

    // Random segments over the idling modes, short random frames
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 77; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 12; stall_pct = 12; end
      endcase
      load_config($urandom_range(4), $urandom_range(3), $urandom_range(3),
                  $urandom_range(3), $urandom_range(3), $urandom_range(3),
                  $urandom_range(8));
      for (int unsigned n = 0; n < SEG_REQS; n++)
        push_req(($urandom_range(9) == 0) ? OP_START : OP_TICK, $urandom());
      finish_frame();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/irpdt_pkg.sv
hw/rtl/irpdt_cfg.sv
hw/rtl/irpdt_core.sv
hw/rtl/ir_pulse_distance_transmitter.sv
hw/rtl/irpdt_chk.sv
tb/tb_ir_pulse_distance_transmitter.sv
